>>> rtl/s2dec_pkg.sv
// Shared constants and types for the signed integer to decimal text block.
package s2dec_pkg;

   localparam int DIGIT_BITS = 4;

   localparam logic [5:0] CHAR_ZERO  = 6'd48;
   localparam logic [5:0] CHAR_NINE  = 6'd57;
   localparam logic [5:0] CHAR_MINUS = 6'd45;

   // double dabble correction: digits of five or more get three added before the shift
   localparam logic [DIGIT_BITS-1:0] DABBLE_LIMIT = 4'd5;
   localparam logic [DIGIT_BITS-1:0] DABBLE_ADD   = 4'd3;

   // handoff from converter to emitter
   typedef struct packed {
      logic load;
      logic neg;
   } conv_done_type;

endpackage

>>> rtl/s2dec_req_if.sv
// Input channel: one signed integer per beat.
interface s2dec_req_if #(
   parameter int VALUE_BITS = 32
);
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

>>> rtl/s2dec_rsp_if.sv
// Result channel: one ASCII character per beat.
interface s2dec_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] text_char;
   logic       is_last;

   modport source (output valid, output text_char, output is_last, input ready);
   modport sink   (input valid, input text_char, input is_last, output ready);
endinterface

>>> rtl/s2dec_conv.sv
// Bit-serial binary to BCD converter (shift and add three), one input bit per cycle.
module s2dec_conv #(
   parameter int VALUE_BITS = 32,
   parameter int NUM_DIGITS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [VALUE_BITS-1:0]         value,
   output logic                          busy,
   output s2dec_pkg::conv_done_type      done,
   output logic [NUM_DIGITS*4-1:0]       bcd
);
   import s2dec_pkg::*;

   localparam int BCD_BITS = NUM_DIGITS * DIGIT_BITS;
   localparam int CNT_W    = $clog2(VALUE_BITS + 1);

   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [BCD_BITS-1:0]   bcd_ff, bcd_in;
   logic [BCD_BITS-1:0]   bcd_adj;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  neg_ff, neg_in;

   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i*DIGIT_BITS +: DIGIT_BITS] >= DABBLE_LIMIT) begin
            bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_ff[i*DIGIT_BITS +: DIGIT_BITS] + DABBLE_ADD;
         end else begin
            bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_ff[i*DIGIT_BITS +: DIGIT_BITS];
         end
      end
   end

   always_comb begin
      mag_in  = mag_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      if (start) begin
         neg_in  = value[VALUE_BITS-1];
         // most negative value negates to itself, read as unsigned magnitude
         mag_in  = value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;
         bcd_in  = '0;
         cnt_in  = CNT_W'(VALUE_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bcd_in = {bcd_adj[BCD_BITS-2:0], mag_ff[VALUE_BITS-1]};
         mag_in = {mag_ff[VALUE_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   assign busy      = busy_ff;
   assign done.load = done_ff;
   assign done.neg  = neg_ff;
   assign bcd       = bcd_ff;

endmodule

>>> rtl/s2dec_emit.sv
// Character emitter: minus sign if negative, then BCD digits top first, leading zeros dropped, beat registered.
module s2dec_emit #(
   parameter int NUM_DIGITS = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   input  s2dec_pkg::conv_done_type load,
   input  logic [NUM_DIGITS*4-1:0]  bcd,
   output logic                     busy,
   s2dec_rsp_if.source              rsp
);
   import s2dec_pkg::*;

   localparam int BCD_BITS = NUM_DIGITS * DIGIT_BITS;
   localparam int LEFT_W   = $clog2(NUM_DIGITS + 1);

   typedef enum logic [2:0] {
      EM_IDLE   = 3'b001,
      EM_SIGN   = 3'b010,
      EM_DIGITS = 3'b100
   } emit_state_type;

   emit_state_type        state_ff, state_in;
   logic [BCD_BITS-1:0]   digits_ff, digits_in;
   logic [LEFT_W-1:0]     left_ff, left_in;
   logic                  started_ff, started_in;
   logic                  out_valid_ff, out_valid_in;
   logic [5:0]            out_char_ff, out_char_in;
   logic                  out_last_ff, out_last_in;
   logic                  slot_free;
   logic                  last_digit;
   logic [DIGIT_BITS-1:0] top_digit;

   assign slot_free  = !out_valid_ff || rsp.ready;
   assign top_digit  = digits_ff[BCD_BITS-1 -: DIGIT_BITS];
   assign last_digit = (left_ff == LEFT_W'(1));

   always_comb begin
      state_in     = state_ff;
      digits_in    = digits_ff;
      left_in      = left_ff;
      started_in   = started_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      unique case (state_ff)
         EM_IDLE: begin
            if (load.load) begin
               digits_in  = bcd;
               left_in    = LEFT_W'(NUM_DIGITS);
               started_in = 1'b0;
               state_in   = load.neg ? EM_SIGN : EM_DIGITS;
            end
         end
         EM_SIGN: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_char_in  = CHAR_MINUS;
               out_last_in  = 1'b0;
               state_in     = EM_DIGITS;
            end
         end
         EM_DIGITS: begin
            // leading zero: skip without a beat; the units digit always goes out
            if (top_digit == '0 && !started_ff && !last_digit) begin
               digits_in = {digits_ff[BCD_BITS-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
               left_in   = left_ff - LEFT_W'(1);
            end else if (slot_free) begin
               out_valid_in = 1'b1;
               out_char_in  = CHAR_ZERO + {2'b00, top_digit};
               out_last_in  = last_digit;
               started_in   = 1'b1;
               digits_in    = {digits_ff[BCD_BITS-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
               left_in      = left_ff - LEFT_W'(1);
               if (last_digit) begin
                  state_in = EM_IDLE;
               end
            end
         end
         default: state_in = EM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= EM_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      digits_ff   <= digits_in;
      left_ff     <= left_in;
      started_ff  <= started_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign busy          = (state_ff != EM_IDLE);
   assign rsp.valid     = out_valid_ff;
   assign rsp.text_char = out_char_ff;
   assign rsp.is_last   = out_last_ff;

endmodule

>>> rtl/signed_int_to_decimal_ascii_top.sv
// Top level: signed integer in, decimal ASCII characters out, one per beat.
//
// Each accepted integer is printed as an optional minus sign followed by its decimal
// digits, most significant first, without leading zeros; the final character carries
// is_last. One number is worked on at a time. After the input beat, a bit-serial
// shift-and-add-three converter builds the BCD digits one input bit at a time, a
// registered done strobe hands them to the emitter, and the emitter then steps through
// every BCD digit position (NUM_DIGITS = VALUE_BITS*3/10 + 1, skipped leading zeros
// included), after a minus sign if the number is negative. Result back-pressure stalls
// only the emitter; the last character sits in an output register so the next number
// can be accepted while it waits.
module signed_int_to_decimal_ascii_top #(
   parameter int VALUE_BITS = 32
) (
   input logic         clock,
   input logic         reset,
   s2dec_req_if.sink   req_chan,
   s2dec_rsp_if.source rsp_chan
);
   import s2dec_pkg::*;

   localparam int NUM_DIGITS = (VALUE_BITS * 3) / 10 + 1;

   logic                         conv_busy;
   logic                         emit_busy;
   logic                         req_fire;
   conv_done_type                conv_done;
   logic [NUM_DIGITS*DIGIT_BITS-1:0] conv_bcd;

   assign req_chan.ready = !conv_busy && !conv_done.load && !emit_busy;
   assign req_fire       = req_chan.valid && req_chan.ready;

   s2dec_conv #(
      .VALUE_BITS (VALUE_BITS),
      .NUM_DIGITS (NUM_DIGITS)
   ) u_conv (
      .clock (clock),
      .reset (reset),
      .start (req_fire),
      .value (req_chan.value),
      .busy  (conv_busy),
      .done  (conv_done),
      .bcd   (conv_bcd)
   );

   s2dec_emit #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_emit (
      .clock (clock),
      .reset (reset),
      .load  (conv_done),
      .bcd   (conv_bcd),
      .busy  (emit_busy),
      .rsp   (rsp_chan)
   );

   a_start_runs_conv: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> conv_busy)
      else $error("accepted beat did not start conversion");

   a_conv_emit_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(conv_busy && emit_busy))
      else $error("converter and emitter busy together");

   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.text_char == CHAR_MINUS ||
                          (rsp_chan.text_char >= CHAR_ZERO &&
                           rsp_chan.text_char <= CHAR_NINE)))
      else $error("result character out of range");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.text_char == CHAR_MINUS) |-> !rsp_chan.is_last)
      else $error("minus sign marked as last character");

endmodule

>>> tb/signed_int_to_decimal_ascii_top_tb.sv
// Testbench for the signed integer to decimal text block: checks every character beat.
module signed_int_to_decimal_ascii_top_tb;
   import s2dec_pkg::*;

   localparam int VALUE_BITS   = 32;
   localparam int NUM_RANDOM   = 350;
   localparam int CYCLE_LIMIT  = 1500000;
   localparam int SETTLE_TICKS = 64;

   typedef struct {
      logic [VALUE_BITS-1:0] value;
      bit                    wait_drain;   // hold until all text so far is out
   } number_item_type;

   typedef struct packed {
      logic [5:0] text_char;
      logic       is_last;
   } text_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic [VALUE_BITS-1:0] req_value = '0;
   logic                  rsp_ready = 1'b0;

   number_item_type numbers_to_send[$];
   text_beat_type   chars_expected[$];
   int              error_count = 0;
   int              cycle_count = 0;
   int              send_gap    = 0;
   int              send_calm   = 0;
   int              hold_left   = 0;
   int              hold_calm   = 0;

   s2dec_req_if #(.VALUE_BITS(VALUE_BITS)) req_chan ();
   s2dec_rsp_if                            rsp_chan ();

   assign req_chan.valid = req_valid;
   assign req_chan.value = req_value;
   assign rsp_chan.ready = rsp_ready;

   signed_int_to_decimal_ascii_top #(.VALUE_BITS(VALUE_BITS)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly short gaps, a few long ones, and now and then a run with none at all.
   function automatic int pick_gap(inout int calm_left);
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 49) == 0) begin
         calm_left = $urandom_range(20, 80);
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Expected text: optional minus, then digits of the unsigned magnitude, MSD first.
   function automatic void predict_text(logic [VALUE_BITS-1:0] value);
      logic [VALUE_BITS-1:0] mag;
      logic [3:0]            digits[$];
      text_beat_type         beat;
      if (value[VALUE_BITS-1]) begin
         mag = ~value + 1'b1;   // most negative value stays as 2^(N-1), unsigned
         beat.text_char = CHAR_MINUS;
         beat.is_last   = 1'b0;
         chars_expected.push_back(beat);
      end else begin
         mag = value;
      end
      do begin
         digits.push_front(4'(mag % 10));
         mag = mag / 10;
      end while (mag != 0);
      for (int i = 0; i < digits.size(); i++) begin
         beat.text_char = CHAR_ZERO + {2'b00, digits[i]};
         beat.is_last   = (i == digits.size() - 1);
         chars_expected.push_back(beat);
      end
   endfunction

   function automatic logic [VALUE_BITS-1:0] random_number();
      logic [VALUE_BITS-1:0] v;
      int unsigned           decade;
      int                    k;
      decade = 1;
      k = $urandom_range(0, 9);
      for (int i = 0; i < k; i++) decade = decade * 10;
      case ($urandom_range(0, 4))
         0, 1: v = $urandom;
         2: v = $urandom_range(0, decade - 1);
         3: v = decade + $urandom_range(0, 4) - 2;
         default: v = $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 3)
                                           : 32'h80000000 + $urandom_range(0, 3);
      endcase
      if ($urandom_range(0, 2) == 0) v = -v;
      return v;
   endfunction

   function automatic void queue_number(logic [VALUE_BITS-1:0] value, bit wait_drain);
      number_item_type item;
      item.value      = value;
      item.wait_drain = wait_drain;
      numbers_to_send.push_back(item);
   endfunction

   always @(posedge clock) begin : drive_req
      logic                  next_valid;
      logic [VALUE_BITS-1:0] next_value;
      number_item_type       item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         next_valid = req_valid;
         next_value = req_value;
         if (req_valid && req_chan.ready) begin
            predict_text(req_value);
            next_valid = 1'b0;
            send_gap   = pick_gap(send_calm);
         end
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (numbers_to_send.size() != 0 &&
                         (!numbers_to_send[0].wait_drain || chars_expected.size() == 0)) begin
               item       = numbers_to_send.pop_front();
               next_valid = 1'b1;
               next_value = item.value;
            end
         end
         req_valid <= next_valid;
         req_value <= next_value;
      end
   end

   always @(posedge clock) begin : watch_rsp
      text_beat_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_ready) begin
            if (chars_expected.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected char beat: text_char=%0d is_last=%0d",
                           rsp_chan.text_char, rsp_chan.is_last);
            end else begin
               want = chars_expected.pop_front();
               if (rsp_chan.text_char !== want.text_char || rsp_chan.is_last !== want.is_last) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("char mismatch: expected text_char=%0d is_last=%0d, got %0d %0d",
                              want.text_char, want.is_last, rsp_chan.text_char, rsp_chan.is_last);
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            hold_left = pick_gap(hold_calm);
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("signed_int_to_decimal_ascii_top verification failed");
         $finish;
      end
   end

   initial begin
      // zero, single digits, decade boundaries, both extremes, alternating bits
      queue_number(32'd0, 1'b0);
      queue_number(32'd1, 1'b0);
      queue_number(-32'sd1, 1'b0);
      queue_number(32'd9, 1'b0);
      queue_number(32'd10, 1'b0);
      queue_number(-32'sd9, 1'b0);
      queue_number(-32'sd10, 1'b0);
      queue_number(32'd99, 1'b0);
      queue_number(32'd100, 1'b0);
      queue_number(32'h7fffffff, 1'b0);
      queue_number(32'h80000000, 1'b0);
      queue_number(32'h80000001, 1'b0);
      queue_number(32'h7ffffffe, 1'b0);
      queue_number(32'd1000000000, 1'b0);
      queue_number(32'd999999999, 1'b0);
      queue_number(-32'sd1000000000, 1'b0);
      queue_number(-32'sd999999999, 1'b0);
      queue_number(32'h55555555, 1'b0);
      queue_number(32'haaaaaaaa, 1'b0);
      queue_number(32'd12345, 1'b0);
      queue_number(-32'sd98765, 1'b0);
      for (int i = 0; i < NUM_RANDOM; i++)
         queue_number(random_number(), i == 0 || $urandom_range(0, 59) == 0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // sample away from the rising edge so driver updates have settled
      do @(negedge clock); while (numbers_to_send.size() != 0 || req_valid);
      while (chars_expected.size() != 0) @(negedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);

      if (error_count == 0 && chars_expected.size() == 0)
         $display("signed_int_to_decimal_ascii_top verification clean");
      else
         $display("signed_int_to_decimal_ascii_top verification failed");
      $finish;
   end

endmodule
